>>> src/sequenced_event_ring_with_ack_macros.svh
// ----------------------------------------------------------------------------
// sequenced event ring assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_EVENT_RING_WITH_ACK_MACROS_SVH
`define SEQUENCED_EVENT_RING_WITH_ACK_MACROS_SVH

// same-cycle implication
`define SERWA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SERWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/serwa_pkg.sv
// ----------------------------------------------------------------------------
// serwa_pkg
// types, codes and fixed widths shared by the event ring modules
// ----------------------------------------------------------------------------
package serwa_pkg;

    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 5;
    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4,
        ST_ACKED     = 3'd5
    } t_status;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] uptime;
        logic [7:0]  etype;
        logic [7:0]  evalue;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic exhaust;
        logic append;
        logic rd_index;
        logic rd_head;
        logic rd_capture;
        logic pop;
        logic ack_end;
        logic oldest_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       stamps_left;
        logic       read_hit;
        logic       empty;
        logic       head_le;
    } t_dp_stat;

endpackage

>>> src/serwa_ctrl.sv
// ----------------------------------------------------------------------------
// serwa_ctrl
// sequencer for append, read and acknowledge requests
// ----------------------------------------------------------------------------
module serwa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output serwa_pkg::t_dp_cmd  o_cmd,
    input  serwa_pkg::t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_APPEND,
        S_RD_CAP,
        S_ACK_ISSUE,
        S_ACK_TEST,
        S_ACK_END,
        S_REFRESH,
        S_REFRESH_CAP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    serwa_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    serwa_pkg::KIND_APPEND: begin
                        if (i_stat.stamps_left) begin
                            n_state = S_APPEND;
                        end else begin
                            cmd.exhaust = 1'b1;
                            n_state     = S_FINISH;
                        end
                    end
                    serwa_pkg::KIND_READ: begin
                        if (i_stat.read_hit) begin
                            cmd.rd_index = 1'b1;
                            n_state      = S_RD_CAP;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    serwa_pkg::KIND_ACK: n_state = S_ACK_ISSUE;
                    default:             n_state = S_FINISH;
                endcase
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                n_state    = S_REFRESH;
            end
            S_RD_CAP: begin
                cmd.rd_capture = 1'b1;
                n_state        = S_FINISH;
            end
            S_ACK_ISSUE: begin
                if (i_stat.empty) begin
                    n_state = S_ACK_END;
                end else begin
                    cmd.rd_head = 1'b1;
                    n_state     = S_ACK_TEST;
                end
            end
            S_ACK_TEST: begin
                if (i_stat.head_le) begin
                    cmd.pop = 1'b1;
                    n_state = S_ACK_ISSUE;
                end else begin
                    n_state = S_ACK_END;
                end
            end
            S_ACK_END: begin
                cmd.ack_end = 1'b1;
                n_state     = S_REFRESH;
            end
            S_REFRESH: begin
                cmd.rd_head = 1'b1;
                n_state     = S_REFRESH_CAP;
            end
            S_REFRESH_CAP: begin
                cmd.oldest_load = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/serwa_dp.sv
// ----------------------------------------------------------------------------
// serwa_dp
// event memory, ring pointers, counters and result register
// ----------------------------------------------------------------------------
module serwa_dp #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_event_type,
    input  logic [7:0]          i_event_value,
    input  logic [31:0]         i_uptime_ms,
    input  logic [15:0]         i_read_index,
    input  logic [31:0]         i_ack_sequence,
    input  serwa_pkg::t_dp_cmd  i_cmd,
    output serwa_pkg::t_dp_stat o_stat,
    output logic [2:0]          o_status,
    output logic [4:0]          o_removed_count,
    output logic [31:0]         o_read_seq,
    output logic [31:0]         o_read_uptime_ms,
    output logic [7:0]          o_read_type,
    output logic [7:0]          o_read_value,
    output logic [4:0]          o_entry_count,
    output logic [31:0]         o_dropped_total,
    output logic [31:0]         o_upcoming_sequence,
    output logic [1:0]          o_flags,
    output logic [31:0]         o_oldest_seq,
    output logic [31:0]         o_last_ack_seq
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int COW = serwa_pkg::CNT_OUT_W;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    serwa_pkg::t_entry r_mem [DEPTH];
    serwa_pkg::t_entry r_rdata;

    logic [1:0]  r_kind;
    logic [7:0]  r_etype;
    logic [7:0]  r_evalue;
    logic [31:0] r_uptime;
    logic [15:0] r_ridx;
    logic [31:0] r_ackseq;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [31:0]   r_drops;
    logic [31:0]   r_next;
    logic          r_left;
    logic [31:0]   r_ack_high;
    logic          r_ack_seen;
    logic [31:0]   r_oldest;

    serwa_pkg::t_status r_status;
    logic [CW-1:0] r_removed;
    logic [31:0]   r_rd_seq;
    logic [31:0]   r_rd_uptime;
    logic [7:0]    r_rd_type;
    logic [7:0]    r_rd_value;

    logic [2:0]  r_o_status;
    logic [4:0]  r_o_removed;
    logic [31:0] r_o_rd_seq;
    logic [31:0] r_o_rd_uptime;
    logic [7:0]  r_o_rd_type;
    logic [7:0]  r_o_rd_value;
    logic [4:0]  r_o_count;
    logic [31:0] r_o_drops;
    logic [31:0] r_o_next;
    logic [1:0]  r_o_flags;
    logic [31:0] r_o_oldest;
    logic [31:0] r_o_ack_high;

    logic          full;
    logic          read_hit;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] read_slot;
    logic [AW-1:0] rd_addr;
    serwa_pkg::t_entry wr_entry;

    assign full      = (r_count == DEPTH_C);
    assign read_hit  = ({1'b0, r_ridx} < 17'(r_count));
    assign head_inc  = f_wrap(r_head, AW'(1));
    assign tail_slot = full ? r_head : f_wrap(r_head, r_count[AW-1:0]);
    assign read_slot = f_wrap(r_head, r_ridx[AW-1:0]);
    assign rd_addr   = i_cmd.rd_index ? read_slot : r_head;

    assign wr_entry.seq    = r_next;
    assign wr_entry.uptime = r_uptime;
    assign wr_entry.etype  = r_etype;
    assign wr_entry.evalue = r_evalue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[tail_slot] <= wr_entry;
        end
        if (i_cmd.rd_index || i_cmd.rd_head) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_drops    <= '0;
            r_next     <= 32'd1;
            r_left     <= 1'b1;
            r_ack_high <= '0;
            r_ack_seen <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_next <= i_cfg_wr_data;
                r_left <= 1'b1;
            end
            if (i_cmd.exhaust) begin
                r_drops <= r_drops + 32'd1;
            end
            if (i_cmd.append) begin
                if (full) begin
                    r_head  <= head_inc;
                    r_drops <= r_drops + 32'd1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                if (r_next == serwa_pkg::SEQ_MAX) begin
                    r_left <= 1'b0;
                end else begin
                    r_next <= r_next + 32'd1;
                end
            end
            if (i_cmd.pop) begin
                r_head  <= head_inc;
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.ack_end && (!r_ack_seen || r_ackseq > r_ack_high)) begin
                r_ack_high <= r_ackseq;
                r_ack_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind      <= i_kind;
            r_etype     <= i_event_type;
            r_evalue    <= i_event_value;
            r_uptime    <= i_uptime_ms;
            r_ridx      <= i_read_index;
            r_ackseq    <= i_ack_sequence;
            r_status    <= serwa_pkg::ST_MISS;
            r_removed   <= '0;
            r_rd_seq    <= '0;
            r_rd_uptime <= '0;
            r_rd_type   <= '0;
            r_rd_value  <= '0;
        end
        if (i_cmd.exhaust) begin
            r_status <= serwa_pkg::ST_EXHAUSTED;
        end
        if (i_cmd.append) begin
            r_status <= full ? serwa_pkg::ST_DROPPED : serwa_pkg::ST_APPENDED;
        end
        if (i_cmd.rd_capture) begin
            r_status    <= serwa_pkg::ST_HIT;
            r_rd_seq    <= r_rdata.seq;
            r_rd_uptime <= r_rdata.uptime;
            r_rd_type   <= r_rdata.etype;
            r_rd_value  <= r_rdata.evalue;
        end
        if (i_cmd.pop) begin
            r_removed <= r_removed + CW'(1);
        end
        if (i_cmd.ack_end) begin
            r_status <= serwa_pkg::ST_ACKED;
        end
        if (i_cmd.oldest_load) begin
            r_oldest <= r_rdata.seq;
        end
        if (i_cmd.out_load) begin
            r_o_status    <= r_status;
            r_o_removed   <= COW'(r_removed);
            r_o_rd_seq    <= r_rd_seq;
            r_o_rd_uptime <= r_rd_uptime;
            r_o_rd_type   <= r_rd_type;
            r_o_rd_value  <= r_rd_value;
            r_o_count     <= COW'(r_count);
            r_o_drops     <= r_drops;
            r_o_next      <= r_next;
            r_o_flags     <= {r_ack_seen, r_left};
            r_o_oldest    <= (r_count != '0) ? r_oldest : 32'd0;
            r_o_ack_high  <= r_ack_high;
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.stamps_left = r_left;
    assign o_stat.read_hit    = read_hit;
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.head_le     = (r_rdata.seq <= r_ackseq);

    assign o_status            = r_o_status;
    assign o_removed_count     = r_o_removed;
    assign o_read_seq          = r_o_rd_seq;
    assign o_read_uptime_ms    = r_o_rd_uptime;
    assign o_read_type         = r_o_rd_type;
    assign o_read_value        = r_o_rd_value;
    assign o_entry_count       = r_o_count;
    assign o_dropped_total     = r_o_drops;
    assign o_upcoming_sequence = r_o_next;
    assign o_flags             = r_o_flags;
    assign o_oldest_seq        = r_o_oldest;
    assign o_last_ack_seq      = r_o_ack_high;

endmodule

>>> src/sequenced_event_ring_with_ack.sv
// ----------------------------------------------------------------------------
// sequenced event ring with acknowledge
// flow: one request in work at a time; a new request is taken only in idle
// an untaken result holds the next back; an acknowledge takes longer per removed entry
// reset: synchronous active low; empty ring, next sequence 1, no clearing pass
// ----------------------------------------------------------------------------
`include "sequenced_event_ring_with_ack_macros.svh"

module sequenced_event_ring_with_ack #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_event_type,
    input  logic [7:0]  i_event_value,
    input  logic [31:0] i_uptime_ms,
    input  logic [15:0] i_read_index,
    input  logic [31:0] i_ack_sequence,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_removed_count,
    output logic [31:0] o_read_seq,
    output logic [31:0] o_read_uptime_ms,
    output logic [7:0]  o_read_type,
    output logic [7:0]  o_read_value,
    output logic [4:0]  o_entry_count,
    output logic [31:0] o_dropped_total,
    output logic [31:0] o_upcoming_sequence,
    output logic [1:0]  o_flags,
    output logic [31:0] o_oldest_seq,
    output logic [31:0] o_last_ack_seq
);

    serwa_pkg::t_dp_cmd  cmd;
    serwa_pkg::t_dp_stat stat;

    serwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    serwa_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_kind              (i_kind),
        .i_event_type        (i_event_type),
        .i_event_value       (i_event_value),
        .i_uptime_ms         (i_uptime_ms),
        .i_read_index        (i_read_index),
        .i_ack_sequence      (i_ack_sequence),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_status            (o_status),
        .o_removed_count     (o_removed_count),
        .o_read_seq          (o_read_seq),
        .o_read_uptime_ms    (o_read_uptime_ms),
        .o_read_type         (o_read_type),
        .o_read_value        (o_read_value),
        .o_entry_count       (o_entry_count),
        .o_dropped_total     (o_dropped_total),
        .o_upcoming_sequence (o_upcoming_sequence),
        .o_flags             (o_flags),
        .o_oldest_seq        (o_oldest_seq),
        .o_last_ack_seq      (o_last_ack_seq)
    );

    `SERWA_ASSERT_IMPLY(a_removed_only_on_ack,
        o_out_valid && (o_removed_count != 5'd0),
        o_status == serwa_pkg::ST_ACKED,
        "removed count outside acknowledge")
    `SERWA_ASSERT_IMPLY(a_read_zero_on_no_hit,
        o_out_valid && (o_status != serwa_pkg::ST_HIT),
        (o_read_seq == 32'd0) && (o_read_uptime_ms == 32'd0)
            && (o_read_type == 8'd0) && (o_read_value == 8'd0),
        "read fields set without hit")
    `SERWA_ASSERT_IMPLY(a_exhausted_at_max,
        o_out_valid && !o_flags[0],
        o_upcoming_sequence == serwa_pkg::SEQ_MAX,
        "sequence exhausted below maximum")
    `SERWA_ASSERT_NEXT(a_one_request_at_a_time,
        i_in_valid && o_in_ready,
        !o_in_ready,
        "second request taken during work")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced event ring testbench
// drives append, read and acknowledge requests through a valid/ready port with
// random gaps and output stalls, predicts every result with a cycle-free ring
// model and compares each result field by field, across several first_sequence
// settings including zero, the top of the range and sequence exhaustion
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_DEPTH = 16;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  etype;
        logic [7:0]  evalue;
        logic [31:0] uptime;
        logic [15:0] ridx;
        logic [31:0] ackseq;
    } t_ring_req;

    typedef struct packed {
        serwa_pkg::t_status status;
        logic [4:0]  removed;
        logic [31:0] rseq;
        logic [31:0] rtime;
        logic [7:0]  rtype;
        logic [7:0]  rval;
        logic [4:0]  count;
        logic [31:0] drops;
        logic [31:0] upcoming;
        logic [1:0]  flags;
        logic [31:0] oldest;
        logic [31:0] last_ack;
    } t_ring_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = serwa_pkg::KIND_APPEND;
    logic [7:0]  i_event_type = '0;
    logic [7:0]  i_event_value = '0;
    logic [31:0] i_uptime_ms = '0;
    logic [15:0] i_read_index = '0;
    logic [31:0] i_ack_sequence = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [4:0]  o_removed_count;
    logic [31:0] o_read_seq;
    logic [31:0] o_read_uptime_ms;
    logic [7:0]  o_read_type;
    logic [7:0]  o_read_value;
    logic [4:0]  o_entry_count;
    logic [31:0] o_dropped_total;
    logic [31:0] o_upcoming_sequence;
    logic [1:0]  o_flags;
    logic [31:0] o_oldest_seq;
    logic [31:0] o_last_ack_seq;

    // ring image
    logic [31:0] ring_seq [RING_DEPTH];
    logic [31:0] ring_time [RING_DEPTH];
    logic [7:0]  ring_type [RING_DEPTH];
    logic [7:0]  ring_val [RING_DEPTH];
    logic [3:0]  head = '0;
    logic [4:0]  held = '0;
    logic [31:0] drop_total = '0;
    logic [31:0] next_stamp = 32'd1;
    logic        stamps_left = 1'b1;
    logic [31:0] ack_high = '0;
    logic        ack_seen = 1'b0;

    t_ring_req    pending_reqs [$];
    t_ring_result results_due [$];
    logic [31:0]  gen_seq = 32'd1;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    int unsigned  n_append = 0;
    int unsigned  n_read = 0;
    int unsigned  n_ack = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_cfg = 0;

    sequenced_event_ring_with_ack #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_event_type        (i_event_type),
        .i_event_value       (i_event_value),
        .i_uptime_ms         (i_uptime_ms),
        .i_read_index        (i_read_index),
        .i_ack_sequence      (i_ack_sequence),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_removed_count     (o_removed_count),
        .o_read_seq          (o_read_seq),
        .o_read_uptime_ms    (o_read_uptime_ms),
        .o_read_type         (o_read_type),
        .o_read_value        (o_read_value),
        .o_entry_count       (o_entry_count),
        .o_dropped_total     (o_dropped_total),
        .o_upcoming_sequence (o_upcoming_sequence),
        .o_flags             (o_flags),
        .o_oldest_seq        (o_oldest_seq),
        .o_last_ack_seq      (o_last_ack_seq)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_ring_result ring_outcome(t_ring_req q);
        t_ring_result r;
        logic [3:0]   slot;
        r = '0;
        r.status = serwa_pkg::ST_MISS;
        case (q.kind)
            serwa_pkg::KIND_APPEND: begin
                if (!stamps_left) begin
                    drop_total++;
                    r.status = serwa_pkg::ST_EXHAUSTED;
                end else begin
                    r.status = serwa_pkg::ST_APPENDED;
                    if (held == RING_DEPTH) begin
                        head++;
                        held--;
                        drop_total++;
                        r.status = serwa_pkg::ST_DROPPED;
                    end
                    slot = head + held[3:0];
                    ring_seq[slot] = next_stamp;
                    ring_time[slot] = q.uptime;
                    ring_type[slot] = q.etype;
                    ring_val[slot] = q.evalue;
                    held++;
                    if (next_stamp == serwa_pkg::SEQ_MAX) stamps_left = 1'b0;
                    else next_stamp++;
                end
            end
            serwa_pkg::KIND_READ: begin
                if (q.ridx < held) begin
                    slot = head + q.ridx[3:0];
                    r.status = serwa_pkg::ST_HIT;
                    r.rseq = ring_seq[slot];
                    r.rtime = ring_time[slot];
                    r.rtype = ring_type[slot];
                    r.rval = ring_val[slot];
                end
            end
            serwa_pkg::KIND_ACK: begin
                r.status = serwa_pkg::ST_ACKED;
                while (held != 0 && ring_seq[head] <= q.ackseq) begin
                    head++;
                    held--;
                    r.removed++;
                end
                if (!ack_seen || q.ackseq > ack_high) begin
                    ack_high = q.ackseq;
                    ack_seen = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = held;
        r.drops = drop_total;
        r.upcoming = next_stamp;
        r.flags = {ack_seen, stamps_left};
        r.oldest = (held != 0) ? ring_seq[head] : 32'd0;
        r.last_ack = ack_high;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic t_ring_req make_req(logic [1:0] kind, logic [7:0] etype,
            logic [7:0] evalue, logic [31:0] uptime, logic [15:0] ridx, logic [31:0] ackseq);
        t_ring_req q;
        q.kind = kind;
        q.etype = etype;
        q.evalue = evalue;
        q.uptime = uptime;
        q.ridx = ridx;
        q.ackseq = ackseq;
        return q;
    endfunction

    function automatic t_ring_req random_req();
        t_ring_req   q;
        int unsigned pick;
        q = make_req(serwa_pkg::KIND_APPEND, 8'($urandom), 8'($urandom), $urandom,
            16'($urandom), $urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            gen_seq++;
        end else if (pick < 75) begin
            q.kind = serwa_pkg::KIND_READ;
            if ($urandom_range(9) != 0) q.ridx = 16'($urandom_range(17));
        end else begin
            q.kind = serwa_pkg::KIND_ACK;
            case ($urandom_range(9))
                0: q.ackseq = '1;
                1: q.ackseq = '0;
                2: ;
                default: q.ackseq = gen_seq - $urandom_range(1, 20);
            endcase
        end
        return q;
    endfunction

    // drain both channels, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_first_seq(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        next_stamp = value;
        stamps_left = 1'b1;
        gen_seq = value;
        n_cfg++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= $urandom;
        @(negedge i_clk);
    endtask

    task automatic random_phase(logic [31:0] first_seq, int unsigned sidle,
            int unsigned ridle, int n);
        settle();
        write_first_seq(first_seq);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (n) pending_reqs.push_back(random_req());
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                results_due.push_back(ring_outcome(make_req(i_kind, i_event_type,
                    i_event_value, i_uptime_ms, i_read_index, i_ack_sequence)));
                case (i_kind)
                    serwa_pkg::KIND_APPEND: n_append++;
                    serwa_pkg::KIND_READ: n_read++;
                    default: n_ack++;
                endcase
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_ring_req q;
                    q = pending_reqs.pop_front();
                    i_kind <= q.kind;
                    i_event_type <= q.etype;
                    i_event_value <= q.evalue;
                    i_uptime_ms <= q.uptime;
                    i_read_index <= q.ridx;
                    i_ack_sequence <= q.ackseq;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result with no request outstanding, status %0d", o_status);
                errors++;
            end else begin
                t_ring_result r;
                r = results_due.pop_front();
                n_checked++;
                check_field("status", 32'(r.status), 32'(o_status));
                check_field("removed_count", 32'(r.removed), 32'(o_removed_count));
                check_field("read_seq", r.rseq, o_read_seq);
                check_field("read_uptime_ms", r.rtime, o_read_uptime_ms);
                check_field("read_type", 32'(r.rtype), 32'(o_read_type));
                check_field("read_value", 32'(r.rval), 32'(o_read_value));
                check_field("entry_count", 32'(r.count), 32'(o_entry_count));
                check_field("dropped_total", r.drops, o_dropped_total);
                check_field("upcoming_sequence", r.upcoming, o_upcoming_sequence);
                check_field("flags", 32'(r.flags), 32'(o_flags));
                check_field("oldest_seq", r.oldest, o_oldest_seq);
                check_field("last_ack_seq", r.last_ack, o_last_ack_seq);
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sequenced_event_ring_with_ack: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 30;
        recv_idle_pct = 82;

        // empty ring, full ring with one overwrite, reads at the edges,
        // lower acknowledge, acknowledge of everything
        pending_reqs.push_back(make_req(serwa_pkg::KIND_ACK, 8'h00, 8'h00, '0, '0, 32'd0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_READ, 8'hFF, 8'hFF, '1, 16'd0, '1));
        for (int i = 0; i < RING_DEPTH + 1; i++)
            pending_reqs.push_back(make_req(serwa_pkg::KIND_APPEND, i[0] ? 8'hFF : 8'(i),
                i[0] ? 8'h00 : 8'hFF - 8'(i), i[1] ? 32'hFFFF_FFFF : 32'(i), '0, '0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_READ, '0, '0, '0, 16'd0, '0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_READ, '0, '0, '0, 16'd15, '0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_READ, '0, '0, '0, 16'd16, '0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_READ, '0, '0, '0, 16'hFFFF, '0));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_ACK, '0, '0, '0, '0, 32'd5));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_ACK, '0, '0, '0, '0, 32'd2));
        pending_reqs.push_back(make_req(serwa_pkg::KIND_ACK, '0, '0, '0, '0, 32'hFFFF_FFFF));
        gen_seq = 32'd1 + RING_DEPTH + 1;

        random_phase(32'd0, 30, 82, 200);
        random_phase(32'hFFFF_FFF8, 30, 82, 150);
        random_phase(32'hFFFF_FFFF, 82, 30, 100);
        random_phase($urandom, 82, 30, 200);
        random_phase(32'd1000, 0, 0, 200);
        settle();

        $display("%0d requests (%0d append, %0d read, %0d acknowledge), %0d results checked",
            n_append + n_read + n_ack, n_append, n_read, n_ack, n_checked);
        $display("%0d first_sequence writes, %0d events dropped at the end", n_cfg, drop_total);
        if (errors == 0) begin
            $display("sequenced_event_ring_with_ack: match");
        end else begin
            $display("sequenced_event_ring_with_ack: mismatch");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/serwa_pkg.sv
src/serwa_ctrl.sv
src/serwa_dp.sv
src/sequenced_event_ring_with_ack.sv
bench/testbench.sv
